// ===== sv/mss_pkg.sv =====
// Package for the multipath slot selector: constants, register indexes and state codes.
// No dependencies.
package mss_pkg;
    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W = 4;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_NODE_ID   = 3'd1;
    localparam logic [2:0] REG_SLOT_CNT  = 3'd2;
    localparam logic [2:0] REG_SLOT_VAL  = 3'd3;
    localparam logic [2:0] REG_SHIFT     = 3'd4;
    localparam logic [2:0] REG_MASK      = 3'd5;
    localparam logic [2:0] REG_R2P2      = 3'd6;

    localparam logic [1:0] MODE_RR = 2'd0;
    localparam logic [1:0] MODE_HASH = 2'd1;
    localparam logic [1:0] MODE_PRIO = 2'd2;
    localparam logic [1:0] MSG_REQ = 2'd1;
    localparam logic [1:0] MSG_GRANT = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_HASH  = 6'b000010,
        ST_MOD   = 6'b000100,
        ST_PROBE = 6'b001000,
        ST_CRC   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;
endpackage

// ===== sv/multipath_slot_selector.sv =====
// Multipath slot selector top level: round-robin, hash and CRC slot choice.
// Depends on mss_pkg.
//
// Channel  | Direction | Handshake       | Payload
// s_       | in        | s_valid/s_ready | header fields
// m_       | out       | m_valid/m_ready | m_slot, m_all_empty
// cfg_     | in        | cfg_we          | cfg_index, cfg_data
//
// Steps: 16 hash steps (skipped in round robin), a modulo of a load and 32 remainder steps,
// a probe set-up and one probe per slot probed, up to 16. When the override applies, 96 CRC
// bit steps and a second modulo follow. ST_OUT raises the result in the cycle after it is
// entered, and s_ready returns in the cycle after the result transfer.
// Reset is synchronous and clears the control state and registers to their defaults.
// The block takes no item until the result has been transferred on the m_ channel.
module multipath_slot_selector (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_src_addr,
    input  logic [31:0] s_dst_addr,
    input  logic signed [31:0] s_flow_id,
    input  logic signed [31:0] s_prio,
    input  logic        s_is_udp,
    input  logic [1:0]  s_msg_type,
    input  logic signed [31:0] s_seq_num,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [mss_pkg::SLOT_W-1:0] m_slot,
    output logic        m_all_empty
);
    import mss_pkg::*;

    logic [1:0]  mode_reg;
    logic [31:0] node_id_reg, mask_reg;
    logic [4:0]  cnt_reg, shift_reg;
    logic [15:0] valid_reg;
    logic        r2p2_reg;
    logic [3:0]  rr_reg;

    state_t      st_reg;
    logic [127:0] key_reg;     // hash key bytes, shifted out low first
    logic [31:0] acc_reg;      // hash, CRC or remainder accumulator
    logic [31:0] prio_reg;
    logic [6:0]  step_reg;
    logic [5:0]  modpos_reg;
    logic [4:0]  n_reg;
    logic [4:0]  start_reg, p_reg;
    logic        crc_reg, is_rr_reg, empty_reg, crcdone_reg;
    logic [3:0]  slot_reg;
    logic        m_valid_reg;
    logic [95:0] crckey_reg;
    logic [31:0] dv_reg;

    function automatic logic [31:0] xform(input logic [31:0] a, input logic [4:0] s,
                                          input logic [31:0] m);
        logic signed [31:0] t;
        t = $signed(a) >>> s;
        xform = t & m;
    endfunction

    logic [4:0] n_eff;
    always_comb begin
        n_eff = cnt_reg;
        if (cnt_reg == 5'd0) n_eff = 5'd1;
        if (cnt_reg > 5'(MAX_SLOTS)) n_eff = 5'(MAX_SLOTS);
    end

    logic [31:0] sb;
    logic [4:0]  p_inc;
    logic        slot_ok;
    assign sb = {{24{key_reg[7]}}, key_reg[7:0]};
    assign p_inc = (p_reg + 5'd1 == n_reg) ? 5'd0 : p_reg + 5'd1;
    assign slot_ok = valid_reg[p_reg[3:0]];

    // A new key byte is folded in on the first bit step of each byte.
    logic [31:0] crc_cur;
    logic [31:0] crc_bit;
    assign crc_cur = (step_reg[2:0] == 3'd0) ? (acc_reg ^ {24'd0, crckey_reg[7:0]}) : acc_reg;
    assign crc_bit = (crc_cur >> 1) ^ (CRC_POLY & {32{crc_cur[0]}});

    logic go_crc;
    assign go_crc = r2p2_reg && s_is_udp && (s_msg_type == MSG_REQ || s_msg_type == MSG_GRANT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 2'd0; node_id_reg <= 32'd0; cnt_reg <= 5'd1; valid_reg <= 16'd0;
            shift_reg <= 5'd0; mask_reg <= 32'hFFFFFFFF; r2p2_reg <= 1'b0; rr_reg <= 4'd0;
            st_reg <= ST_IDLE; m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MODE:     mode_reg <= cfg_data[1:0];
                    REG_NODE_ID:  node_id_reg <= cfg_data;
                    REG_SLOT_CNT: cnt_reg <= cfg_data[4:0];
                    REG_SLOT_VAL: valid_reg <= cfg_data[15:0];
                    REG_SHIFT:    shift_reg <= cfg_data[4:0];
                    REG_MASK:     mask_reg <= cfg_data;
                    REG_R2P2:     r2p2_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            case (st_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        n_reg <= n_eff;
                        prio_reg <= (mode_reg == MODE_HASH) ? 32'd0 : s_prio;
                        crc_reg <= go_crc;
                        crcdone_reg <= 1'b0;
                        is_rr_reg <= (mode_reg == MODE_RR);
                        key_reg <= {s_flow_id, xform(s_dst_addr, shift_reg, mask_reg),
                                    xform(s_src_addr, shift_reg, mask_reg), node_id_reg};
                        step_reg <= 7'd0;
                        if (mode_reg == MODE_RR) begin
                            // Stale pointer reduced modulo n by the shared divider.
                            acc_reg <= {28'd0, rr_reg};
                            modpos_reg <= 6'd0;
                            st_reg <= ST_MOD;
                        end else begin
                            acc_reg <= 32'd0;
                            st_reg <= ST_HASH;
                        end
                        // Raw CRC key parked for the override pass.
                        crckey_reg <= (s_msg_type == MSG_REQ) ?
                                      {s_seq_num, s_src_addr, s_dst_addr} :
                                      {s_seq_num, s_dst_addr, s_src_addr};
                    end
                end
                ST_HASH: begin
                    key_reg <= key_reg >> 8;
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'd15) begin
                        acc_reg <= acc_reg * 32'd9 + sb + prio_reg;
                        modpos_reg <= 6'd0;
                        st_reg <= ST_MOD;
                    end else begin
                        acc_reg <= acc_reg * 32'd9 + sb;
                    end
                end
                ST_MOD: begin
                    // Restoring division, one quotient bit a step; only the remainder is
                    // kept. Partial remainder in acc_reg, dividend bits from dv_reg top first.
                    if (modpos_reg == 6'd0) begin
                        dv_reg <= acc_reg;
                        acc_reg <= 32'd0;
                        modpos_reg <= 6'd1;
                    end else begin
                        acc_reg <= ({acc_reg[30:0], dv_reg[31]} >= {27'd0, n_reg}) ?
                                   {acc_reg[30:0], dv_reg[31]} - {27'd0, n_reg} :
                                   {acc_reg[30:0], dv_reg[31]};
                        dv_reg <= dv_reg << 1;
                        modpos_reg <= modpos_reg + 6'd1;
                        if (modpos_reg == 6'd32) st_reg <= crcdone_reg ? ST_OUT : ST_PROBE;
                    end
                end
                ST_PROBE: begin
                    if (step_reg[6] == 1'b0 && modpos_reg != 6'd0) begin
                        start_reg <= acc_reg[4:0];
                        p_reg <= acc_reg[4:0];
                        step_reg <= 7'h40;
                        modpos_reg <= 6'd0;
                    end else begin
                        slot_reg <= p_reg[3:0];
                        empty_reg <= !slot_ok;
                        p_reg <= p_inc;
                        if (slot_ok || p_inc == start_reg) begin
                            if (is_rr_reg) rr_reg <= slot_ok ? p_inc[3:0] : start_reg[3:0];
                            if (crc_reg) begin
                                acc_reg <= 32'hFFFFFFFF;
                                step_reg <= 7'd0;
                                st_reg <= ST_CRC;
                            end else begin
                                st_reg <= ST_OUT;
                            end
                        end
                    end
                end
                ST_CRC: begin
                    if (step_reg[2:0] == 3'd7) crckey_reg <= crckey_reg >> 8;
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'd95) begin
                        acc_reg <= ~crc_bit;
                        crcdone_reg <= 1'b1;
                        modpos_reg <= 6'd0;
                        st_reg <= ST_MOD;
                    end else begin
                        acc_reg <= crc_bit;
                    end
                end
                ST_OUT: begin
                    if (crcdone_reg) slot_reg <= acc_reg[3:0];
                    if (!m_valid_reg) begin
                        m_valid_reg <= 1'b1;
                    end else if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (st_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_slot = slot_reg;
    assign m_all_empty = empty_reg;
endmodule

// ===== sv/mss_checker.sv =====
// Port-level checker for the multipath slot selector.
// Depends on mss_pkg; bound to multipath_slot_selector.
module mss_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic [mss_pkg::SLOT_W-1:0] m_slot
);
    import mss_pkg::*;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while a result is pending");
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("ready after transfer");
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid) else $error("result too early");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_slot)) else $error("result dropped");
endmodule

bind multipath_slot_selector mss_checker u_mss_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_slot(m_slot)
);

// ===== sim/multipath_slot_selector_test.sv =====
// Self-checking testbench for the multipath slot selector: directed table then random traffic.
// Depends on mss_pkg and multipath_slot_selector; the expected slots come from a local model.
`timescale 1ns / 100ps

module multipath_slot_selector_test;
    import mss_pkg::*;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] fid;
        logic [31:0] prio;
        logic        udp;
        logic [1:0]  msg;
        logic [31:0] seq;
    } hdr_t;

    typedef struct packed {
        logic [3:0] slot;
        logic       empty;
    } pick_t;

    // Directed row: header, whether a typed-in result applies, and that result.
    typedef struct packed {
        hdr_t  hdr;
        logic  fixed;
        pick_t want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_MODE;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    hdr_t        hdr_drv = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_slot;
    logic        m_all_empty;

    // Shadow copy of the configuration and the pointer.
    logic [1:0]  cur_mode = MODE_RR;
    logic [31:0] cur_node = '0;
    logic [4:0]  cur_count = 5'd1;
    logic [15:0] cur_valid = '0;
    logic [4:0]  cur_shift = '0;
    logic [31:0] cur_mask = '1;
    logic        cur_r2p2 = 1'b0;
    logic [3:0]  rr_ptr = '0;

    pick_t       pending_picks[$];
    int          errors = 0;
    int          send_idle = 0;
    int          recv_stall = 0;

    always #5 aclk = ~aclk;

    multipath_slot_selector dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_src_addr(hdr_drv.src), .s_dst_addr(hdr_drv.dst),
        .s_flow_id(hdr_drv.fid), .s_prio(hdr_drv.prio),
        .s_is_udp(hdr_drv.udp), .s_msg_type(hdr_drv.msg), .s_seq_num(hdr_drv.seq),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_slot(m_slot), .m_all_empty(m_all_empty)
    );

    function automatic logic [31:0] addr_key(logic [31:0] a);
        logic signed [31:0] t;
        t = $signed(a) >>> cur_shift;
        return t & cur_mask;
    endfunction

    function automatic logic [31:0] mix_word(logic [31:0] h, logic [31:0] w);
        for (int k = 0; k < 4; k++)
            h = h * 32'd9 + {{24{w[8*k+7]}}, w[8*k +: 8]};
        return h;
    endfunction

    function automatic logic [31:0] crc_word(logic [31:0] c, logic [31:0] w);
        for (int k = 0; k < 4; k++) begin
            c ^= {24'd0, w[8*k +: 8]};
            for (int j = 0; j < 8; j++)
                c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    // Computes the slot for one header and advances the round-robin pointer.
    function automatic pick_t choose_slot(hdr_t h);
        int          n;
        int          start;
        int          p;
        int          cand;
        logic [31:0] hv;
        logic [31:0] c;
        pick_t       r;
        n = (cur_count == 0) ? 1 : (cur_count > MAX_SLOTS) ? MAX_SLOTS : int'(cur_count);
        if (cur_mode == MODE_RR) begin
            start = int'(rr_ptr) % n;
        end else begin
            hv = mix_word(32'd0, cur_node);
            hv = mix_word(hv, addr_key(h.src));
            hv = mix_word(hv, addr_key(h.dst));
            hv = mix_word(hv, h.fid);
            if (cur_mode >= MODE_PRIO) hv += h.prio;
            start = int'(hv % n);
        end
        p = start;
        do begin
            cand = p;
            p = (p + 1) % n;
        end while (!cur_valid[cand] && p != start);
        r.slot = cand[3:0];
        r.empty = !cur_valid[cand];
        if (cur_mode == MODE_RR) rr_ptr = p[3:0];
        if (cur_r2p2 && h.udp && (h.msg == MSG_REQ || h.msg == MSG_GRANT)) begin
            c = crc_word(32'hFFFFFFFF, (h.msg == MSG_REQ) ? h.dst : h.src);
            c = crc_word(c, (h.msg == MSG_REQ) ? h.src : h.dst);
            c = ~crc_word(c, h.seq);
            r.slot = 4'(c % n);
        end
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE:     cur_mode = val[1:0];
            REG_NODE_ID:  cur_node = val;
            REG_SLOT_CNT: cur_count = val[4:0];
            REG_SLOT_VAL: cur_valid = val[15:0];
            REG_SHIFT:    cur_shift = val[4:0];
            REG_MASK:     cur_mask = val;
            REG_R2P2:     cur_r2p2 = val[0];
            default: ;
        endcase
    endtask

    task automatic drain;
        while (pending_picks.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    // Offers one header and holds it until the transfer; an optional gap goes first.
    task automatic send_hdr(hdr_t h, logic fixed, pick_t want);
        pick_t p;
        @(negedge aclk);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge aclk);
        end
        hdr_drv <= h;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        p = choose_slot(h);
        if (fixed && p != want) begin
            $error("table row disagrees with model: slot %0d/%0d empty %0d/%0d",
                   want.slot, p.slot, want.empty, p.empty);
            errors++;
        end
        pending_picks.push_back(p);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    function automatic hdr_t rand_hdr();
        hdr_t h;
        h.src = $urandom;
        h.dst = $urandom;
        h.fid = $urandom;
        h.prio = $urandom;
        h.udp = 1'($urandom_range(1));
        h.msg = 2'($urandom_range(3));
        h.seq = $urandom;
        if ($urandom_range(7) == 0) h.src = {32{h.src[0]}};
        return h;
    endfunction

    // Result checking at the rising edge.
    always @(posedge aclk) begin
        pick_t exp_pick;
        if (aresetn && m_valid && m_ready) begin
            if (pending_picks.size() == 0) begin
                $error("result transfer with nothing expected: slot %0d", m_slot);
                errors++;
            end else begin
                exp_pick = pending_picks.pop_front();
                if (m_slot !== exp_pick.slot) begin
                    $error("slot: expected %0d, got %0d", exp_pick.slot, m_slot);
                    errors++;
                end
                if (m_all_empty !== exp_pick.empty) begin
                    $error("all_empty: expected %0d, got %0d", exp_pick.empty, m_all_empty);
                    errors++;
                end
            end
        end
    end

    always @(negedge aclk)
        m_ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);

    initial begin
        #20_000_000;
        $display("multipath_slot_selector_test: done, errors");
        $finish;
    end

    initial begin
        row_t  rows[12];
        pick_t none;
        int    idle_set[4][2];
        none = '0;
        idle_set = '{'{0, 0}, '{55, 0}, '{0, 55}, '{13, 13}};
        // After reset there is one slot and it is empty, so every result is slot 0, empty.
        rows[0] = '{'{32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 2'd0, 32'h0}, 1'b1, '{4'd0, 1'b1}};
        rows[1] = '{'{'1, '1, '1, '1, 1'b1, 2'd3, '1}, 1'b1, '{4'd0, 1'b1}};
        rows[2] = '{'{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                      1'b1, MSG_REQ, 32'h80000000}, 1'b1, '{4'd0, 1'b1}};
        for (int i = 3; i < 12; i++)
            rows[i] = '{'{$urandom, $urandom, $urandom, $urandom, 1'(i[0]), 2'(i % 4),
                          $urandom}, 1'b0, none};

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < 3; i++) send_hdr(rows[i].hdr, rows[i].fixed, rows[i].want);
        drain();

        // Directed: round robin with holes, then the hash modes, then the override.
        write_reg(REG_SLOT_CNT, 32'd16);
        write_reg(REG_SLOT_VAL, 32'h8421);
        for (int i = 3; i < 7; i++) send_hdr(rows[i].hdr, 1'b0, none);
        drain();
        write_reg(REG_SLOT_CNT, 32'd5);    // fewer slots for the hash modes
        write_reg(REG_MODE, 32'd1);
        write_reg(REG_NODE_ID, 32'h80000000);
        write_reg(REG_SHIFT, 32'd31);
        write_reg(REG_MASK, 32'h0000FFFF);
        for (int i = 7; i < 9; i++) send_hdr(rows[i].hdr, 1'b0, none);
        drain();
        write_reg(REG_MODE, 32'd3);        // mode three behaves as hash plus prio
        write_reg(REG_R2P2, 32'd1);
        write_reg(REG_SLOT_CNT, 32'd0);    // a count of zero behaves as one
        for (int i = 9; i < 12; i++) send_hdr(rows[i].hdr, 1'b0, none);
        send_hdr('{$urandom, $urandom, $urandom, $urandom, 1'b1, MSG_GRANT, $urandom},
                 1'b0, none);
        drain();
        write_reg(REG_SLOT_CNT, 32'd31);   // saturates at the maximum
        write_reg(REG_SLOT_VAL, 32'hFFFF);
        send_hdr('{$urandom, $urandom, 32'h7FFFFFFF, 32'h80000000, 1'b1, MSG_REQ, 32'h7FFFFFFF},
                 1'b0, none);
        drain();

        // Random phases, each with a fresh configuration and one of four idling patterns in turn.
        for (int ph = 0; ph < 16; ph++) begin
            send_idle = idle_set[ph % 4][0];
            recv_stall = idle_set[ph % 4][1];
            write_reg(REG_MODE, $urandom_range(3));
            write_reg(REG_NODE_ID, $urandom);
            write_reg(REG_SLOT_CNT, (ph % 5 == 0) ? 32'd16 : $urandom_range(31));
            write_reg(REG_SLOT_VAL, (ph % 6 == 0) ? 32'd0 : $urandom_range(16'hFFFF));
            write_reg(REG_SHIFT, (ph % 7 == 0) ? 32'd31 : $urandom_range(31));
            write_reg(REG_MASK, (ph % 3 == 0) ? 32'hFFFFFFFF : $urandom);
            write_reg(REG_R2P2, $urandom_range(1));
            for (int i = 0; i < 96; i++) send_hdr(rand_hdr(), 1'b0, none);
            drain();
        end

        if (errors == 0 && pending_picks.size() == 0)
            $display("multipath_slot_selector_test: done, clean");
        else
            $display("multipath_slot_selector_test: done, errors");
        $finish;
    end
endmodule
